// File: sv/address_mapping_table_defines.svh
// Assertion macros for the address mapping table.
// Used by the top level only; the including module must have clk and rst in scope.
`ifndef ADDRESS_MAPPING_TABLE_DEFINES_SVH
`define ADDRESS_MAPPING_TABLE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define AMT_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define AMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/amt_pkg.sv
// Shared types and constants for the address mapping table.
// No dependencies; imported by the top level.
package amt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAC_W             = 48;
  localparam int MIP_W             = 8;
  localparam int FUNC_W            = 2;
  localparam int STATUS_W          = 3;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [MAC_W-1:0]    mac_t;
  typedef logic [MIP_W-1:0]    mip_t;

  // Request codes.
  localparam func_t FUNC_ADD    = 2'd0;
  localparam func_t FUNC_BY_MIP = 2'd1;
  localparam func_t FUNC_BY_MAC = 2'd2;

  // Result codes.
  localparam status_t ST_ADDED   = 3'd0;
  localparam status_t ST_PRESENT = 3'd1;
  localparam status_t ST_FOUND   = 3'd2;
  localparam status_t ST_MISSING = 3'd3;
  localparam status_t ST_FULL    = 3'd4;

endpackage

// File: sv/amt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; used for the table entry storage.
module amt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/address_mapping_table.sv
// Address mapping table top level: sequencer, valid bits, compare unit and output register.
// Depends on amt_pkg, amt_ram and address_mapping_table_defines.svh.
//
//   port group                  dir   handshake             word
//   in  (func, mac/mip_address) in    in_valid / in_ready   one request
//   out (status, mac/mip_found) out   out_valid / out_ready one result
//
// Each request walks every entry through the one RAM read port: the scan state
// steps through the entries, then the decide state registers the result, and the
// block is busy until the result is taken. The walk is set by the single read port.
// Reset clears the entry valid bits and the sequencer at once; no clearing pass.
// A stalled result holds in the output register and keeps in_ready low.
`include "address_mapping_table_defines.svh"

module address_mapping_table #(
  parameter int TABLE_ENTRIES = amt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  amt_pkg::func_t    func,
  input  amt_pkg::mac_t     mac_address,
  input  amt_pkg::mip_t     mip_address,
  output logic              out_valid,
  input  logic              out_ready,
  output amt_pkg::status_t  status,
  output amt_pkg::mac_t     mac_found,
  output amt_pkg::mip_t     mip_found
);

  import amt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int EW = MAC_W + MIP_W;
  localparam logic [CW-1:0] SCAN_END = CW'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t                  state;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           cnt_m1;
  logic [IW-1:0]           pidx;
  func_t                   func_q;
  mac_t                    mac_q;
  mip_t                    mip_q;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [TABLE_ENTRIES-1:0] valid_next;
  logic                    hit_ip;
  logic [IW-1:0]           ip_idx;
  logic                    hit_hw;
  logic [IW-1:0]           hw_idx;
  mac_t                    hit_mac;
  mip_t                    hit_mip;
  logic                    free_ok;
  logic [IW-1:0]           free_idx;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [EW-1:0]           ram_wdata;
  logic [EW-1:0]           ram_rdata;
  mac_t                    rd_mac;
  mip_t                    rd_mip;
  logic                    e_valid;
  logic                    mac_eq;
  logic                    mip_eq;

  logic                    present;
  logic                    slot_ok;
  logic [IW-1:0]           slot;
  status_t                 status_next;

  amt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Compare unit: the entry read last cycle against both keys.
  assign cnt_m1 = cnt - CW'(1);
  assign pidx   = cnt_m1[IW-1:0];
  assign rd_mac = ram_rdata[EW-1:MIP_W];
  assign rd_mip = ram_rdata[MIP_W-1:0];
  assign e_valid = valid[pidx];
  assign mac_eq  = e_valid && (rd_mac == mac_q);
  assign mip_eq  = e_valid && (rd_mip == mip_q);

  // Add decision: lowest free slot once the hit entries are freed.
  always_comb begin
    present = hit_ip && hit_hw && (ip_idx == hw_idx);
    slot_ok = free_ok;
    slot    = free_idx;
    if (hit_ip && (!slot_ok || (ip_idx < slot))) begin
      slot_ok = 1'b1;
      slot    = ip_idx;
    end
    if (hit_hw && (!slot_ok || (hw_idx < slot))) begin
      slot_ok = 1'b1;
      slot    = hw_idx;
    end
  end

  // Table update and result code.
  always_comb begin
    valid_next  = valid;
    ram_we      = 1'b0;
    ram_waddr   = slot;
    ram_wdata   = {mac_q, mip_q};
    status_next = ST_MISSING;
    case (func_q)
      FUNC_ADD: begin
        if (present) begin
          status_next = ST_PRESENT;
        end else if (slot_ok) begin
          status_next = ST_ADDED;
        end else begin
          status_next = ST_FULL;
        end
      end
      FUNC_BY_MIP: begin
        if (hit_ip) begin
          status_next = ST_FOUND;
        end
      end
      FUNC_BY_MAC: begin
        if (hit_hw) begin
          status_next = ST_FOUND;
        end
      end
      default: status_next = ST_MISSING;
    endcase
    if ((state == S_DECIDE) && (func_q == FUNC_ADD) && !present) begin
      if (hit_ip) begin
        valid_next[ip_idx] = 1'b0;
      end
      if (hit_hw) begin
        valid_next[hw_idx] = 1'b0;
      end
      if (slot_ok) begin
        valid_next[slot] = 1'b1;
        ram_we           = 1'b1;
      end
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      valid <= '0;
    end else begin
      valid <= valid_next;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
            cnt   <= '0;
          end
        end
        S_SCAN: begin
          cnt <= cnt + CW'(1);
          if (cnt == SCAN_END) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request capture, scan results and output register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      func_q  <= func;
      mac_q   <= mac_address;
      mip_q   <= mip_address;
      hit_ip  <= 1'b0;
      hit_hw  <= 1'b0;
      free_ok <= 1'b0;
    end
    if ((state == S_SCAN) && (cnt != '0)) begin
      if (mip_eq && !hit_ip) begin
        hit_ip  <= 1'b1;
        ip_idx  <= pidx;
        hit_mac <= rd_mac;
      end
      if (mac_eq && !hit_hw) begin
        hit_hw  <= 1'b1;
        hw_idx  <= pidx;
        hit_mip <= rd_mip;
      end
      if (!e_valid && !free_ok) begin
        free_ok  <= 1'b1;
        free_idx <= pidx;
      end
    end
    if (state == S_DECIDE) begin
      status    <= status_next;
      mac_found <= ((func_q == FUNC_BY_MIP) && hit_ip) ? hit_mac : '0;
      mip_found <= ((func_q == FUNC_BY_MAC) && hit_hw) ? hit_mip : '0;
    end
  end

  // Checks on the sequencer.
  `AMT_ASSERT_HOLDS(a_ready_result_excl, !(in_ready && out_valid), "ready while result pending")
  `AMT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `AMT_ASSERT_NEXT(a_result_after_decide, state == S_DECIDE, out_valid, "no result after decide")
  `AMT_ASSERT_HOLDS(a_found_on_lookup, !(out_valid && status == ST_FOUND && func_q == FUNC_ADD), "found on add")

endmodule
